// ===== hw/rtl/p2coa_pkg.sv =====
// ----------------------------------------------------------------------------
// p2coa_pkg
// Types and constants shared by the power-of-two class offset allocator.
// ----------------------------------------------------------------------------
package p2coa_pkg;

   localparam int ARENA_LOG2     = 21;
   localparam int MIN_CLASS_LOG2 = 3;
   localparam int NUM_CLASSES    = 21;
   localparam int STACK_DEPTH    = 16;

   localparam int OFFSET_W    = ARENA_LOG2;
   localparam int TOP_W       = ARENA_LOG2 + 1;
   localparam int CLASS_W     = $clog2(NUM_CLASSES + 1);
   localparam int CIDX_W      = $clog2(NUM_CLASSES);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int STORE_DEPTH = NUM_CLASSES * STACK_DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam logic [TOP_W-1:0] ARENA_BYTES = TOP_W'(1) << ARENA_LOG2;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OOM       = 2'd1,
      ST_TOO_LARGE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      action_type          action;
      logic [OFFSET_W-1:0] req_bytes;
      logic [OFFSET_W-1:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] granted_offset;
      status_type          status;
   } rsp_type;

endpackage

// ===== hw/rtl/pow2_class_offset_allocator.sv =====
// ----------------------------------------------------------------------------
// pow2_class_offset_allocator
// Power-of-two size-class allocator over one arena, with per-class free
// stacks held in a RAM and a bump top pointer.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand in one request; busy stays high until
// the answer has been worked out, and the answer appears on rsp_item for one
// cycle with rsp_strobe high, in the cycle busy falls; it must be captured
// then. A request first steps its class c up from MIN_CLASS_LOG2, one class
// per step, until 2^c covers the size, then takes a decision step, which
// finishes bump allocations and all frees. An allocation served from the free
// stacks then scans upward for the nearest non-empty class k, reads the stack
// RAM, and pushes the (k - c) split remainders, one RAM write each. Every step
// runs through the class and index registers and the single write and single
// read port of the stack RAM. csr_data may be written at any time the block is
// idle; the register is sampled on every csr transfer.
// ----------------------------------------------------------------------------
module pow2_class_offset_allocator
   import p2coa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLASS,
      S_DECIDE,
      S_SEARCH,
      S_POP,
      S_SPLIT
   } state_type;

   state_type           state_ff, state_in;
   req_type             req_ff, req_in;
   logic [CLASS_W-1:0]  cls_ff, cls_in;
   logic [CLASS_W-1:0]  idx_ff, idx_in;
   logic [TOP_W-1:0]    top_ff, top_in;
   logic                reuse_ff, reuse_in;
   logic [CNT_W-1:0]    cnt_ff [NUM_CLASSES];
   logic [CNT_W-1:0]    cnt_in [NUM_CLASSES];
   logic [OFFSET_W-1:0] piece_ff, piece_in;
   logic [OFFSET_W-1:0] grant_ff, grant_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   rsp_type             rsp_item_ff, rsp_item_in;

   logic [TOP_W-1:0]    cls_size;
   logic [TOP_W-1:0]    idx_size;
   logic [TOP_W-1:0]    bump_sum;
   logic [TOP_W-1:0]    free_end;
   logic [CNT_W-1:0]    cnt_rd;
   logic                idx_valid;

   logic                fin;
   status_type          fin_status;
   logic [OFFSET_W-1:0] fin_grant;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [OFFSET_W-1:0] ram_wdata;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [OFFSET_W-1:0] ram_rdata;

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [CLASS_W-1:0] cls,
                                                   input logic [CNT_W-1:0] slot);
      return ADDR_W'(cls) * ADDR_W'(STACK_DEPTH) + ADDR_W'(slot);
   endfunction

   p2coa_ram #(
      .WIDTH (OFFSET_W),
      .DEPTH (STORE_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign cls_size  = TOP_W'(1) << cls_ff;
   assign idx_size  = TOP_W'(1) << idx_ff;
   assign bump_sum  = top_ff + cls_size;
   assign free_end  = TOP_W'(req_ff.free_offset) + cls_size;
   assign idx_valid = (idx_ff < CLASS_W'(NUM_CLASSES));
   assign cnt_rd    = idx_valid ? cnt_ff[idx_ff[CIDX_W-1:0]] : '0;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      cls_in        = cls_ff;
      idx_in        = idx_ff;
      top_in        = top_ff;
      reuse_in      = reuse_ff;
      cnt_in        = cnt_ff;
      piece_in      = piece_ff;
      grant_in      = grant_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      fin           = 1'b0;
      fin_status    = ST_OK;
      fin_grant     = '0;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = '0;

      if (csr_valid && csr_ready) begin
         reuse_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               cls_in   = CLASS_W'(MIN_CLASS_LOG2);
               idx_in   = CLASS_W'(MIN_CLASS_LOG2);
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            // advance the class until 2^c covers the size
            if (cls_ff == CLASS_W'(NUM_CLASSES)) begin
               fin        = 1'b1;
               fin_status = ST_TOO_LARGE;
            end else if (cls_size < TOP_W'(req_ff.req_bytes)) begin
               cls_in = cls_ff + 1'b1;
               idx_in = cls_ff + 1'b1;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (req_ff.action == ACT_ALLOC) begin
               if (bump_sum <= ARENA_BYTES) begin
                  top_in     = bump_sum;
                  fin        = 1'b1;
                  fin_grant  = top_ff[OFFSET_W-1:0];
               end else if (reuse_ff) begin
                  fin        = 1'b1;
                  fin_status = ST_OOM;
               end else begin
                  state_in = S_SEARCH;
               end
            end else begin
               if (top_ff == free_end) begin
                  top_in = TOP_W'(req_ff.free_offset);
                  fin    = 1'b1;
               end else if (reuse_ff) begin
                  fin = 1'b1;
               end else if (cnt_rd >= CNT_W'(STACK_DEPTH)) begin
                  fin        = 1'b1;
                  fin_status = ST_FULL;
               end else begin
                  ram_we      = 1'b1;
                  ram_waddr   = slot_addr(idx_ff, cnt_rd);
                  ram_wdata   = req_ff.free_offset;
                  cnt_in[idx_ff[CIDX_W-1:0]] = cnt_rd + 1'b1;
                  fin         = 1'b1;
               end
            end
         end
         S_SEARCH: begin
            // classes passed over are empty, so the split never meets a full stack
            if (!idx_valid) begin
               fin        = 1'b1;
               fin_status = ST_OOM;
            end else if (cnt_rd == '0) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               ram_raddr = slot_addr(idx_ff, cnt_rd - 1'b1);
               cnt_in[idx_ff[CIDX_W-1:0]] = cnt_rd - 1'b1;
               state_in = S_POP;
            end
         end
         S_POP: begin
            grant_in = ram_rdata;
            piece_in = ram_rdata + cls_size[OFFSET_W-1:0];
            if (idx_ff == cls_ff) begin
               fin       = 1'b1;
               fin_grant = ram_rdata;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            // push one remainder piece per class, largest first
            ram_we    = 1'b1;
            ram_waddr = slot_addr(idx_ff, cnt_rd);
            ram_wdata = piece_ff;
            cnt_in[idx_ff[CIDX_W-1:0]] = cnt_rd + 1'b1;
            piece_in  = piece_ff + idx_size[OFFSET_W-1:0];
            if (idx_ff == cls_ff) begin
               fin       = 1'b1;
               fin_grant = grant_ff;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         state_in                   = S_IDLE;
         rsp_strobe_in              = 1'b1;
         rsp_item_in.status         = fin_status;
         rsp_item_in.granted_offset = (fin_status == ST_OK) ? fin_grant : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         top_ff        <= '0;
         reuse_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         top_ff        <= top_in;
         reuse_ff      <= reuse_in;
         rsp_strobe_ff <= rsp_strobe_in;
         cnt_ff        <= cnt_in;
      end
      req_ff      <= req_in;
      cls_ff      <= cls_in;
      idx_ff      <= idx_in;
      piece_ff    <= piece_in;
      grant_ff    <= grant_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;
   assign csr_ready  = 1'b1;

endmodule

// ===== hw/rtl/p2coa_ram.sv =====
// ----------------------------------------------------------------------------
// p2coa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module p2coa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/p2coa_checker.sv =====
// ----------------------------------------------------------------------------
// p2coa_checker
// Port-level checks on the allocator's request and response timing.
// ----------------------------------------------------------------------------
module p2coa_checker
   import p2coa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // an accepted request always occupies the block
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // a response ends the request: busy is low while it shows
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response shown while busy");

   // busy drops only when the response is delivered
   a_fall_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_strobe)
      else $error("request finished without a response");

   // no two responses in consecutive cycles
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for two cycles");

   // failed requests grant nothing
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_item.status != ST_OK) |-> (rsp_item.granted_offset == '0))
      else $error("non-zero offset on a failed request");

endmodule

bind pow2_class_offset_allocator p2coa_checker u_p2coa_checker (.*);
